[design/wsd_pkg.sv]
// Package for the websocket frame deframer.
// Holds parse phase, event codes, opcodes and the result and status structs.
// No dependencies.
package wsd_pkg;

   typedef enum logic [2:0] {
      PH_HDR0  = 3'd0,
      PH_HDR1  = 3'd1,
      PH_EXT16 = 3'd2,
      PH_EXT64 = 3'd3,
      PH_KEY   = 3'd4,
      PH_DATA  = 3'd5,
      PH_SKIP  = 3'd6
   } phase_type;

   localparam logic [1:0] EV_PAYLOAD   = 2'd0;
   localparam logic [1:0] EV_HEADER    = 2'd1;
   localparam logic [1:0] EV_CLOSE     = 2'd2;
   localparam logic [1:0] EV_TOO_LARGE = 2'd3;

   localparam logic [3:0] OP_CLOSE = 4'd8;
   localparam logic [3:0] OP_PING  = 4'd9;
   localparam logic [3:0] OP_PONG  = 4'd10;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   localparam int unsigned LEN_W = 31;

   typedef struct packed {
      logic             valid;
      logic [1:0]       event_res;
      logic [7:0]       payload_byte;
      logic [3:0]       frame_opcode_out;
      logic [LEN_W-1:0] frame_length;
      logic             last_in_frame;
   } result_type;

   typedef struct packed {
      logic      failed;
      phase_type phase;
   } status_type;

endpackage

[design/wsd_parser.sv]
// Frame header parser and payload unmasker for the websocket deframer.
// Holds all parse state; one byte is processed per step.
// Depends on wsd_pkg.
module wsd_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         rx_byte,
   output wsd_pkg::result_type res,
   output wsd_pkg::status_type status
);
   import wsd_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [3:0]       opcode_ff, opcode_in;
   logic             mask_ff, mask_in;
   logic [31:0]      acc_ff, acc_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic             upper_ff, upper_in;
   logic [31:0]      key_ff, key_in;
   logic [1:0]       mpos_ff, mpos_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic             failed_ff, failed_in;

   // shared decode
   logic             act;
   logic [3:0]       cnt_inc;
   logic [31:0]      acc_nxt;
   logic             upper_nxt;
   logic             ext16_done, ext64_done, too_big;
   logic             len_done, mask_cur, key_done, hdr_done;
   logic [LEN_W-1:0] hdr_len;
   logic             is_close, is_ctrl;
   logic [LEN_W-1:0] rem_dec;
   logic             pay_last;
   logic [7:0]       key_byte, pay_byte;

   assign act     = step && !failed_ff;
   assign cnt_inc = cnt_ff + 4'd1;

   always_comb begin
      acc_nxt   = acc_ff;
      upper_nxt = upper_ff;
      case (phase_ff)
         PH_HDR1: begin
            upper_nxt = 1'b0;
            if (rx_byte[6:0] == LEN_EXT16 || rx_byte[6:0] == LEN_EXT64) begin
               acc_nxt = 32'd0;
            end else begin
               acc_nxt = {25'd0, rx_byte[6:0]};
            end
         end
         PH_EXT16: acc_nxt = {16'd0, acc_ff[7:0], rx_byte};
         PH_EXT64: begin
            if (cnt_ff < 4'd4) begin
               upper_nxt = upper_ff || (rx_byte != 8'd0);
            end else begin
               acc_nxt = {acc_ff[23:0], rx_byte};
            end
         end
         default: acc_nxt = acc_ff;
      endcase
   end

   assign ext16_done = (phase_ff == PH_EXT16) && (cnt_inc >= 4'd2);
   assign ext64_done = (phase_ff == PH_EXT64) && (cnt_inc >= 4'd8);
   assign too_big    = ext64_done && (upper_nxt || acc_nxt[31]);
   assign len_done   = ((phase_ff == PH_HDR1) && (rx_byte[6:0] < LEN_EXT16))
                       || ext16_done || (ext64_done && !too_big);
   assign mask_cur   = (phase_ff == PH_HDR1) ? rx_byte[7] : mask_ff;
   assign key_done   = (phase_ff == PH_KEY) && (cnt_inc >= 4'd4);
   assign hdr_done   = (len_done && !mask_cur) || key_done;
   assign hdr_len    = acc_nxt[LEN_W-1:0];
   assign is_close   = (opcode_ff == OP_CLOSE);
   assign is_ctrl    = (opcode_ff == OP_PING) || (opcode_ff == OP_PONG);

   assign rem_dec    = rem_ff - {{(LEN_W-1){1'b0}}, 1'b1};
   assign pay_last   = (rem_dec == '0);

   always_comb begin
      case (mpos_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   assign pay_byte = mask_ff ? (rx_byte ^ key_byte) : rx_byte;

   // next state
   always_comb begin
      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      mask_in   = mask_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      upper_in  = upper_ff;
      key_in    = key_ff;
      mpos_in   = mpos_ff;
      rem_in    = rem_ff;
      failed_in = failed_ff;
      if (act) begin
         case (phase_ff)
            PH_HDR0: begin
               opcode_in = rx_byte[3:0];
               phase_in  = PH_HDR1;
            end
            PH_HDR1: begin
               mask_in  = rx_byte[7];
               acc_in   = acc_nxt;
               cnt_in   = 4'd0;
               upper_in = 1'b0;
               if (rx_byte[6:0] == LEN_EXT16) begin
                  phase_in = PH_EXT16;
               end else if (rx_byte[6:0] == LEN_EXT64) begin
                  phase_in = PH_EXT64;
               end
            end
            PH_EXT16: begin
               acc_in = acc_nxt;
               cnt_in = cnt_inc;
            end
            PH_EXT64: begin
               acc_in   = acc_nxt;
               upper_in = upper_nxt;
               cnt_in   = cnt_inc;
               if (too_big) begin
                  failed_in = 1'b1;
               end
            end
            PH_KEY: begin
               key_in = {key_ff[23:0], rx_byte};
               cnt_in = cnt_inc;
               if (key_done) begin
                  mpos_in = 2'd0;
               end
            end
            PH_DATA, PH_SKIP: begin
               if (mask_ff) begin
                  mpos_in = mpos_ff + 2'd1;
               end
               rem_in = rem_dec;
               if (pay_last) begin
                  phase_in = PH_HDR0;
               end
            end
            default: phase_in = PH_HDR0;
         endcase

         // length complete on a masked frame: fetch the key
         if (len_done && mask_cur) begin
            phase_in = PH_KEY;
            cnt_in   = 4'd0;
            key_in   = 32'd0;
            mpos_in  = 2'd0;
         end

         if (hdr_done) begin
            rem_in = hdr_len;
            if (is_close) begin
               failed_in = 1'b1;
            end else if (is_ctrl) begin
               phase_in = (hdr_len != '0) ? PH_SKIP : PH_HDR0;
            end else begin
               phase_in = (hdr_len != '0) ? PH_DATA : PH_HDR0;
            end
         end
      end
   end

   // result
   always_comb begin
      res                  = '0;
      res.frame_opcode_out = opcode_ff;
      if (act) begin
         if (too_big) begin
            res.valid     = 1'b1;
            res.event_res = EV_TOO_LARGE;
         end else if (hdr_done && is_close) begin
            res.valid     = 1'b1;
            res.event_res = EV_CLOSE;
         end else if (hdr_done && !is_ctrl) begin
            res.valid         = 1'b1;
            res.event_res     = EV_HEADER;
            res.frame_length  = hdr_len;
            res.last_in_frame = (hdr_len == '0);
         end else if (phase_ff == PH_DATA) begin
            res.valid         = 1'b1;
            res.event_res     = EV_PAYLOAD;
            res.payload_byte  = pay_byte;
            res.last_in_frame = pay_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         opcode_ff <= '0;
         mask_ff   <= 1'b0;
         acc_ff    <= '0;
         cnt_ff    <= '0;
         upper_ff  <= 1'b0;
         key_ff    <= '0;
         mpos_ff   <= '0;
         rem_ff    <= '0;
         failed_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         mask_ff   <= mask_in;
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
         upper_ff  <= upper_in;
         key_ff    <= key_in;
         mpos_ff   <= mpos_in;
         rem_ff    <= rem_in;
         failed_ff <= failed_in;
      end
   end

   assign status.failed = failed_ff;
   assign status.phase  = phase_ff;

endmodule

[design/websocket_frame_deframer_top.sv]
// Websocket frame deframer, top level: input beat register, parser, result register.
// Data path: the input beat is registered, the parser steps on it when the result slot frees,
// and the parser's result beat is captured in the result register.
// Throughput: one byte per cycle while the receiver does not stall the result register.
// Reset: synchronous; parse restarts at the first header byte, failure flag clears.
// Depends on wsd_pkg and wsd_parser.
module websocket_frame_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] payload_byte, [11:8] frame_opcode_out,
                                    // [42:12] frame_length, zero above
   output logic [1:0]  rsp_tuser,   // [1:0] event_res
   output logic        rsp_tlast    // last_in_frame
);
   import wsd_pkg::*;

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       out_vld_ff, out_vld_in;
   result_type out_ff, out_in;
   logic       advance;
   result_type res;
   status_type status;

   // the result slot frees when empty or being taken
   assign advance    = !out_vld_ff || rsp_tready;
   assign req_tready = !in_vld_ff || advance;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_byte_in = in_byte_ff;
      if (req_tready) begin
         in_vld_in  = req_tvalid;
         in_byte_in = req_tdata;
      end
   end

   wsd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (in_vld_ff && advance),
      .rx_byte (in_byte_ff),
      .res     (res),
      .status  (status)
   );

   always_comb begin
      out_vld_in = out_vld_ff;
      out_in     = out_ff;
      if (advance) begin
         out_vld_in = in_vld_ff && res.valid;
         out_in     = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {5'd0, out_ff.frame_length, out_ff.frame_opcode_out,
                        out_ff.payload_byte};
   assign rsp_tuser  = out_ff.event_res;
   assign rsp_tlast  = out_ff.last_in_frame;

   a_fail_reported: assert property (@(posedge clock) disable iff (reset)
      $rose(status.failed) |-> out_vld_ff
         && (out_ff.event_res == EV_CLOSE || out_ff.event_res == EV_TOO_LARGE))
      else $error("failure entered without an error result");

   a_silent_when_failed: assert property (@(posedge clock) disable iff (reset)
      status.failed |-> !res.valid)
      else $error("parser produced a result after failure");

   a_header_last: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_ff.event_res == EV_HEADER
         |-> out_ff.last_in_frame == (out_ff.frame_length == '0))
      else $error("header last flag disagrees with frame length");

   a_stall_holds_byte: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !advance |=> in_vld_ff && $stable(in_byte_ff))
      else $error("input beat lost while result stalled");

endmodule

[test/websocket_frame_deframer_top_tb.sv]
// Testbench for websocket_frame_deframer_top: streams frames byte by byte and checks every
// result beat against an in-bench frame parser or typed opening rows, under several idle and stall patterns.
// Depends on wsd_pkg and the deframer RTL.
module websocket_frame_deframer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wsd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned PHASE_BEATS = 470;
   localparam int unsigned HOLD_CYCLES = 240;

   typedef struct packed {
      logic [1:0]  ev;
      logic [7:0]  data;
      logic [3:0]  opcode;
      logic [30:0] length;
      logic        last;
   } frame_event_type;

   typedef enum logic [1:0] {BEAT_MODEL, BEAT_QUIET, BEAT_EXPECT} beat_kind_type;
   typedef enum logic [1:0] {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_type;

   typedef struct packed {
      logic [7:0]      data;
      beat_kind_type   kind;
      frame_event_type ev;
   } stim_beat_type;

   // opening frames; typed rows carry the result read straight off the frame layout
   localparam stim_beat_type OPENING_BEATS [25] = '{
      // unmasked text frame of two bytes, payload passes unchanged
      '{8'h81, BEAT_QUIET, '0},
      '{8'h02, BEAT_EXPECT, '{EV_HEADER, 8'h00, 4'h1, 31'd2, 1'b0}},
      '{8'h00, BEAT_EXPECT, '{EV_PAYLOAD, 8'h00, 4'h1, 31'd0, 1'b0}},
      '{8'hFF, BEAT_EXPECT, '{EV_PAYLOAD, 8'hFF, 4'h1, 31'd0, 1'b1}},
      // zero-length binary frame with FIN clear
      '{8'h02, BEAT_QUIET, '0},
      '{8'h00, BEAT_EXPECT, '{EV_HEADER, 8'h00, 4'h2, 31'd0, 1'b1}},
      // ping with one payload byte: all dropped
      '{8'h89, BEAT_QUIET, '0},
      '{8'h01, BEAT_QUIET, '0},
      '{8'h5A, BEAT_QUIET, '0},
      // masked zero-length pong with RSV bits set
      '{8'h7A, BEAT_QUIET, '0},
      '{8'h80, BEAT_QUIET, '0},
      '{8'hA5, BEAT_QUIET, '0},
      '{8'h5A, BEAT_QUIET, '0},
      '{8'h00, BEAT_QUIET, '0},
      '{8'hFF, BEAT_QUIET, '0},
      // reserved opcode, masked, 16-bit length of two
      '{8'h03, BEAT_QUIET, '0},
      '{8'hFE, BEAT_QUIET, '0},
      '{8'h00, BEAT_QUIET, '0},
      '{8'h02, BEAT_QUIET, '0},
      '{8'h12, BEAT_QUIET, '0},
      '{8'h34, BEAT_QUIET, '0},
      '{8'h56, BEAT_QUIET, '0},
      '{8'h78, BEAT_EXPECT, '{EV_HEADER, 8'h00, 4'h3, 31'd2, 1'b0}},
      '{8'hFF, BEAT_MODEL, '0},
      '{8'h00, BEAT_MODEL, '0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   websocket_frame_deframer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // parser state mirrored in the bench
   phase_type   parse_at = PH_HDR0;
   logic [3:0]  opcode_now = 4'h0;
   logic        key_on = 1'b0;
   logic [31:0] len_gather = 32'd0;
   logic [3:0]  hdr_count = 4'd0;
   logic        len_high_set = 1'b0;
   logic [31:0] key_word = 32'd0;
   logic [1:0]  key_pos = 2'd0;
   logic [30:0] bytes_left = 31'd0;
   logic        parser_dead = 1'b0;

   stim_beat_type   rx_stream [$];
   frame_event_type pending_events [$];
   stim_beat_type   offered;
   frame_event_type modeled;
   frame_event_type want_event;
   bit              modeled_hit;

   int unsigned  send_idle_pct = 0;
   int unsigned  recv_stall_pct = 0;
   int unsigned  stream_beats = 0;
   int unsigned  errors = 0;
   int unsigned  cycle_count = 0;
   int unsigned  hold_left = 0;
   bit           hold_trigger = 1'b0;
   bit           hold_used = 1'b0;

   // header complete: act on the opcode with the gathered length
   function automatic bit header_done(output frame_event_type r);
      r = '0;
      r.opcode = opcode_now;
      bytes_left = len_gather[30:0];
      if (opcode_now == OP_CLOSE) begin
         parser_dead = 1'b1;
         r.ev = EV_CLOSE;
         return 1'b1;
      end
      if (opcode_now == OP_PING || opcode_now == OP_PONG) begin
         parse_at = (bytes_left != 0) ? PH_SKIP : PH_HDR0;
         return 1'b0;
      end
      parse_at = (bytes_left != 0) ? PH_DATA : PH_HDR0;
      r.ev = EV_HEADER;
      r.length = bytes_left;
      r.last = (bytes_left == 0);
      return 1'b1;
   endfunction

   function automatic bit length_done(output frame_event_type r);
      r = '0;
      if (key_on) begin
         parse_at = PH_KEY;
         hdr_count = 4'd0;
         key_word = 32'd0;
         key_pos = 2'd0;
         return 1'b0;
      end
      return header_done(r);
   endfunction

   // advance the parser by one received byte; returns 1 when a result is due
   function automatic bit deframe_byte(input logic [7:0] b, output frame_event_type r);
      logic [7:0] kb;
      logic [7:0] d;
      logic       last;
      r = '0;
      r.opcode = opcode_now;
      if (parser_dead)
         return 1'b0;
      case (parse_at)
         PH_HDR0: begin
            opcode_now = b[3:0];
            parse_at = PH_HDR1;
            return 1'b0;
         end
         PH_HDR1: begin
            key_on = b[7];
            len_gather = {25'd0, b[6:0]};
            hdr_count = 4'd0;
            len_high_set = 1'b0;
            if (b[6:0] == LEN_EXT16) begin
               len_gather = 32'd0;
               parse_at = PH_EXT16;
               return 1'b0;
            end
            if (b[6:0] == LEN_EXT64) begin
               len_gather = 32'd0;
               parse_at = PH_EXT64;
               return 1'b0;
            end
            return length_done(r);
         end
         PH_EXT16: begin
            len_gather = {16'd0, len_gather[7:0], b};
            hdr_count = hdr_count + 4'd1;
            if (hdr_count < 4'd2)
               return 1'b0;
            return length_done(r);
         end
         PH_EXT64: begin
            if (hdr_count < 4'd4) begin
               if (b != 8'h00)
                  len_high_set = 1'b1;
            end else begin
               len_gather = {len_gather[23:0], b};
            end
            hdr_count = hdr_count + 4'd1;
            if (hdr_count < 4'd8)
               return 1'b0;
            if (len_high_set || len_gather[31]) begin
               parser_dead = 1'b1;
               r.ev = EV_TOO_LARGE;
               return 1'b1;
            end
            return length_done(r);
         end
         PH_KEY: begin
            key_word = {key_word[23:0], b};
            hdr_count = hdr_count + 4'd1;
            if (hdr_count < 4'd4)
               return 1'b0;
            key_pos = 2'd0;
            return header_done(r);
         end
         PH_DATA, PH_SKIP: begin
            kb = key_word[31 - 8*key_pos -: 8];
            d = b;
            if (key_on) begin
               d = b ^ kb;
               key_pos = key_pos + 2'd1;
            end
            bytes_left = bytes_left - 31'd1;
            last = (bytes_left == 0);
            if (parse_at == PH_SKIP) begin
               if (last)
                  parse_at = PH_HDR0;
               return 1'b0;
            end
            if (last)
               parse_at = PH_HDR0;
            r.ev = EV_PAYLOAD;
            r.data = d;
            r.last = last;
            return 1'b1;
         end
         default: begin
            parse_at = PH_HDR0;
            return 1'b0;
         end
      endcase
   endfunction

   function automatic void flag_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         errors++;
      end
   endfunction

   // sender: predict on each accepted beat, then offer the next one
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            modeled_hit = deframe_byte(offered.data, modeled);
            case (offered.kind)
               BEAT_MODEL:  if (modeled_hit) pending_events.push_back(modeled);
               BEAT_EXPECT: pending_events.push_back(offered.ev);
               default: ;
            endcase
         end
         if (!req_tvalid || req_tready) begin
            if (rx_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered = rx_stream.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= offered.data;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, once, so the block backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_trigger && !hold_used) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // receiver: check each accepted result beat against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_events.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, actual ev %0h data %0h",
                        $time, rsp_tuser, rsp_tdata);
               errors++;
            end else begin
               want_event = pending_events.pop_front();
               flag_field("event", 32'(want_event.ev), 32'(rsp_tuser));
               flag_field("payload", 32'(want_event.data), 32'(rsp_tdata[7:0]));
               flag_field("opcode", 32'(want_event.opcode), 32'(rsp_tdata[11:8]));
               flag_field("length", 32'(want_event.length), 32'(rsp_tdata[42:12]));
               flag_field("last", 32'(want_event.last), 32'(rsp_tlast));
               flag_field("tdata pad", 32'd0, 32'(rsp_tdata[47:43]));
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_events.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic put(input logic [7:0] b);
      rx_stream.push_back('{b, BEAT_MODEL, '0});
      stream_beats++;
   endtask

   task automatic add_header(input logic [3:0] op, input bit masked, input logic [31:0] len);
      len_form_type form;
      logic [31:0]  key;
      if (len > 32'd65535)
         form = FORM_EXT64;
      else if (len > 32'd125)
         form = $urandom_range(1) ? FORM_EXT16 : FORM_EXT64;
      else if ($urandom_range(9) < 8)
         form = FORM_SHORT;
      else
         form = $urandom_range(1) ? FORM_EXT16 : FORM_EXT64;
      put({4'($urandom_range(15)), op});
      case (form)
         FORM_SHORT: put({masked, len[6:0]});
         FORM_EXT16: begin
            put({masked, LEN_EXT16});
            put(len[15:8]);
            put(len[7:0]);
         end
         default: begin
            put({masked, LEN_EXT64});
            repeat (4) put(8'h00);
            put(len[31:24]);
            put(len[23:16]);
            put(len[15:8]);
            put(len[7:0]);
         end
      endcase
      if (masked) begin
         key = $urandom;
         put(key[31:24]);
         put(key[23:16]);
         put(key[15:8]);
         put(key[7:0]);
      end
   endtask

   task automatic add_random_frame();
      logic [3:0]  op;
      logic [31:0] len;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 15) begin
         op = $urandom_range(1) ? OP_PING : OP_PONG;
      end else begin
         op = 4'($urandom_range(15));
         while (op == OP_CLOSE || op == OP_PING || op == OP_PONG)
            op = 4'($urandom_range(15));
      end
      pick = $urandom_range(99);
      if (pick < 65)
         len = $urandom_range(16);
      else if (pick < 90)
         len = $urandom_range(125, 17);
      else
         len = $urandom_range(400, 126);
      add_header(op, $urandom_range(99) < 70, len);
      for (int unsigned i = 0; i < len; i++) begin
         pick = $urandom_range(9);
         put(pick == 0 ? 8'h00 : (pick == 1 ? 8'hFF : 8'($urandom_range(255))));
      end
   endtask

   initial begin
      int unsigned send_pct [4];
      int unsigned recv_pct [4];
      int unsigned target;
      int unsigned slot;
      send_pct = '{0, 53, 0, 20};
      recv_pct = '{0, 0, 53, 20};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      foreach (OPENING_BEATS[i])
         rx_stream.push_back(OPENING_BEATS[i]);
      while (rx_stream.size() != 0)
         @(negedge clock);

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_pct[p];
         recv_stall_pct = recv_pct[p];
         if (p == 0)
            hold_trigger = 1'b1;
         target = stream_beats + PHASE_BEATS;
         while (stream_beats < target)
            add_random_frame();
         while (rx_stream.size() != 0)
            @(negedge clock);
      end

      // the run ends on one terminal frame: a fatal one leaves the parser failed for good
      case ($urandom_range(3))
         0: add_header(OP_CLOSE, 1'($urandom_range(1)), $urandom_range(20));
         1: begin
            // oversized 64-bit length, upper word nonzero
            put({4'($urandom_range(15)), 4'h2});
            put({1'($urandom_range(1)), LEN_EXT64});
            slot = $urandom_range(3);
            for (int i = 0; i < 4; i++)
               put(i == slot ? 8'($urandom_range(255, 1)) : 8'h00);
            repeat (4) put(8'($urandom_range(255)));
         end
         2: begin
            // oversized 64-bit length, bit 31 set
            put({4'($urandom_range(15)), 4'h1});
            put({1'($urandom_range(1)), LEN_EXT64});
            repeat (4) put(8'h00);
            put(8'($urandom_range(255, 128)));
            repeat (3) put(8'($urandom_range(255)));
         end
         default: add_header(4'h2, 1'($urandom_range(1)), 32'h7FFF_FFFF);
      endcase
      repeat (24) put(8'($urandom_range(255)));

      while (rx_stream.size() != 0 || req_tvalid)
         @(negedge clock);
      recv_stall_pct = 0;
      while (pending_events.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);

      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
